// ----- sv/pva_pkg.sv -----
`default_nettype none
package pva_pkg;

	localparam int CordicSteps = 22;
	localparam int NormTop     = 40;
	localparam int Deg90Z      = 5898240;
	localparam int Deg180Z     = 11796480;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [14:0] angle_deg_q7;
		logic [2:0]  vertex_index;
		logic        degenerate;
		logic        overflowed;
		logic        last_result;
	} result_t;

	// neighbour vectors of one vertex, handed from front to back
	typedef struct packed {
		logic signed [16:0] ax;
		logic signed [16:0] ay;
		logic signed [16:0] bx;
		logic signed [16:0] by;
		logic [2:0]         vertex_index;
		logic               degenerate;
		logic               overflowed;
		logic               last_result;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

	typedef enum logic {
		F_LOAD,
		F_GEN
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SETUP,
		B_NORM,
		B_ROT,
		B_FIN
	} back_state_t;

	// atan(2^-k) in degrees*65536
	function automatic logic [21:0] atan_lut(input logic [4:0] k);
		logic [21:0] r;
		case (k)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			5'd20: r = 22'd4;
			5'd21: r = 22'd2;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/polygon_vertex_angles.sv -----
`default_nettype none
// Loads a closed polygon one vertex per start transfer and,
// after the vertex marked last, emits one angle per stored vertex in index
// order, each on result for a single cycle with result_valid high. busy rises
// on the last vertex and falls after the final result. The front reads the
// previous, current and next vertex from vertex memory for each vertex. The
// back then pops the job, forms the four products on a shared multiplier,
// sets up the rotation, normalizes, runs the 22 sequential cordic steps and
// finishes the angle. A degenerate vertex is reported from its pop alone.
// The receiver cannot stall; results are never held.
module polygon_vertex_angles #(
	parameter int MAX_VERTICES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire pva_pkg::vertex_t vertex,
	output logic                  result_valid,
	output pva_pkg::result_t      result
);
	import pva_pkg::*;

	qctl_t qctl;
	job_t  fjob, bjob;
	logic  qfull, qempty, pop, take;

	assign take = start && !busy;

	pva_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.vertex(vertex),
		.qfull (qfull),
		.qctl  (qctl),
		.job   (fjob)
	);

	pva_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (qctl.push),
		.wdata (fjob),
		.pop   (pop),
		.rdata (bjob),
		.full  (qfull),
		.empty (qempty)
	);

	pva_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qempty(qempty),
		.job   (bjob),
		.pop   (pop),
		.valid (result_valid),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
		end else if (take && vertex.last_vertex) begin
			busy <= 1'b1;
		end else if (result_valid && result.last_result) begin
			busy <= 1'b0;
		end
	end

	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result outside a polygon");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.angle_deg_q7 == '0)
		else $error("degenerate angle not zero");
	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.angle_deg_q7 <= 15'd23040) else $error("angle range");
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(take && vertex.last_vertex)) else $error("busy rose");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.push |-> !qfull) else $error("push into full queue");

endmodule
`default_nettype wire

// ----- sv/pva_ram.sv -----
`default_nettype none
module pva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/pva_fifo.sv -----
`default_nettype none
module pva_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pva_pkg::job_t wdata,
	input  wire logic          pop,
	output pva_pkg::job_t      rdata,
	output logic               full,
	output logic               empty
);
	import pva_pkg::*;

	job_t       ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wptr_q <= ~wptr_q;
			end
			if (pop && !empty) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// ----- sv/pva_front.sv -----
`default_nettype none
module pva_front #(
	parameter int MAX_VERTICES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire pva_pkg::vertex_t vertex,
	input  wire logic             qfull,
	output pva_pkg::qctl_t        qctl,
	output pva_pkg::job_t         job
);
	import pva_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);

	front_state_t     state_q, state_d;
	logic [CW-1:0]    cnt_q, n_q;
	logic             ovf_q, jovf_q;
	logic [AW-1:0]    i_q, raddr, p_idx, q_idx;
	logic [2:0]       ph_q;
	logic [31:0]      rdata, prev_q, cur_q, next_q;
	logic             we, room, last_i;

	assign room   = (cnt_q < CW'(MAX_VERTICES));
	assign we     = (state_q == F_LOAD) && take && room;
	assign last_i = ({1'b0, i_q} == (AW + 1)'(n_q) - (AW + 1)'(1));
	assign p_idx  = (i_q == '0) ? AW'(n_q - CW'(1)) : i_q - AW'(1);
	assign q_idx  = last_i ? '0 : i_q + AW'(1);

	always_comb begin
		case (ph_q)
			3'd0:    raddr = p_idx;
			3'd1:    raddr = i_q;
			default: raddr = q_idx;
		endcase
	end

	pva_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata({vertex.vertex_x, vertex.vertex_y}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		logic signed [16:0] cx, cy;
		cx = {cur_q[31], cur_q[31:16]};
		cy = {cur_q[15], cur_q[15:0]};
		job.ax = {prev_q[31], prev_q[31:16]} - cx;
		job.ay = {prev_q[15], prev_q[15:0]} - cy;
		job.bx = {next_q[31], next_q[31:16]} - cx;
		job.by = {next_q[15], next_q[15:0]} - cy;
		job.degenerate = ((job.ax == '0) && (job.ay == '0)) ||
			((job.bx == '0) && (job.by == '0));
		job.vertex_index = 3'(i_q);
		job.overflowed   = jovf_q;
		job.last_result  = last_i;
		qctl.push = (state_q == F_GEN) && (ph_q == 3'd4) && !qfull;
		qctl.full = qfull;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_LOAD:  if (take && vertex.last_vertex) state_d = F_GEN;
			F_GEN:   if (qctl.push && last_i) state_d = F_LOAD;
			default: state_d = F_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			3'd1:    prev_q <= rdata;
			3'd2:    cur_q  <= rdata;
			3'd3:    next_q <= rdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
			jovf_q  <= 1'b0;
			i_q     <= '0;
			ph_q    <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == F_LOAD && take) begin
				if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (vertex.last_vertex) begin
					n_q    <= room ? cnt_q + CW'(1) : cnt_q;
					jovf_q <= ovf_q || !room;
					i_q    <= '0;
					ph_q   <= 3'd0;
				end
			end
			if (state_q == F_GEN) begin
				if (ph_q != 3'd4) begin
					ph_q <= ph_q + 3'd1;
				end else if (qctl.push) begin
					ph_q <= 3'd0;
					if (last_i) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/pva_back.sv -----
`default_nettype none
module pva_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          qempty,
	input  wire pva_pkg::job_t job,
	output logic               pop,
	output logic               valid,
	output pva_pkg::result_t   result
);
	import pva_pkg::*;

	localparam int XW = 44;
	localparam int ZW = 26;

	back_state_t        state_q, state_d;
	job_t               job_q;
	logic [2:0]         mph_q;
	logic [4:0]         k_q;
	logic signed [33:0] prod_q;
	logic signed [35:0] d_q, c_q;
	logic signed [XW-1:0] x_q, y_q, m;
	logic signed [ZW-1:0] z_q;
	logic signed [16:0] ma, mb;

	function automatic logic signed [XW-1:0] shr_t(input logic signed [XW-1:0] v,
			input logic [4:0] k);
		logic [XW-1:0] mag;
		mag = v[XW-1] ? XW'(-v) : v;
		mag = mag >> k;
		return v[XW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	assign pop = (state_q == B_IDLE) && !qempty;
	assign m   = (x_q > y_q) ? x_q : y_q;

	always_comb begin
		case (mph_q)
			3'd0:    begin ma = job_q.ax; mb = job_q.bx; end
			3'd1:    begin ma = job_q.ay; mb = job_q.by; end
			3'd2:    begin ma = job_q.ax; mb = job_q.by; end
			default: begin ma = job_q.ay; mb = job_q.bx; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (pop && !job.degenerate) state_d = B_MUL;
			B_MUL:   if (mph_q == 3'd4) state_d = B_SETUP;
			B_SETUP: state_d = B_NORM;
			B_NORM:  if (m == '0 || m >= (XW'(1) <<< NormTop)) state_d = B_ROT;
			B_ROT:   if (k_q == 5'(CordicSteps - 1)) state_d = B_FIN;
			B_FIN:   state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		logic signed [XW-1:0] xs, ys;
		logic signed [ZW-1:0] zc;
		logic [35:0] cabs;
		logic [24:0] zr;
		xs = shr_t(x_q, k_q);
		ys = shr_t(y_q, k_q);
		case (state_q)
			B_IDLE: begin
				job_q <= job;
				mph_q <= 3'd0;
				result.angle_deg_q7 <= '0;
				result.vertex_index <= job.vertex_index;
				result.degenerate   <= job.degenerate;
				result.overflowed   <= job.overflowed;
				result.last_result  <= job.last_result;
			end
			B_MUL: begin
				mph_q  <= mph_q + 3'd1;
				prod_q <= ma * mb;
				case (mph_q)
					3'd1:    d_q <= 36'(prod_q);
					3'd2:    d_q <= d_q + 36'(prod_q);
					3'd3:    c_q <= 36'(prod_q);
					3'd4:    c_q <= c_q - 36'(prod_q);
					default: ;
				endcase
			end
			B_SETUP: begin
				k_q  <= 5'd0;
				cabs = c_q[35] ? 36'(-c_q) : c_q;
				if (!d_q[35]) begin
					x_q <= XW'(d_q);
					y_q <= XW'($signed({1'b0, cabs}));
					z_q <= '0;
				end else begin
					x_q <= XW'($signed({1'b0, cabs}));
					y_q <= XW'(-d_q);
					z_q <= ZW'(Deg90Z);
				end
			end
			B_NORM: begin
				if (m == '0 || m >= (XW'(1) <<< NormTop)) begin
				end else if (m < (XW'(1) <<< (NormTop - 16))) begin
					x_q <= x_q <<< 16; y_q <= y_q <<< 16;
				end else if (m < (XW'(1) <<< (NormTop - 8))) begin
					x_q <= x_q <<< 8; y_q <= y_q <<< 8;
				end else if (m < (XW'(1) <<< (NormTop - 4))) begin
					x_q <= x_q <<< 4; y_q <= y_q <<< 4;
				end else if (m < (XW'(1) <<< (NormTop - 2))) begin
					x_q <= x_q <<< 2; y_q <= y_q <<< 2;
				end else begin
					x_q <= x_q <<< 1; y_q <= y_q <<< 1;
				end
			end
			B_ROT: begin
				k_q <= k_q + 5'd1;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + ZW'(atan_lut(k_q));
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - ZW'(atan_lut(k_q));
				end
			end
			B_FIN: begin
				if (z_q < 0) begin
					zc = '0;
				end else if (z_q > ZW'(Deg180Z)) begin
					zc = ZW'(Deg180Z);
				end else begin
					zc = z_q;
				end
				zr = 25'(zc) + 25'd256;
				result.angle_deg_q7 <= zr[23:9];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid   <= (pop && job.degenerate) || (state_q == B_FIN);
		end
	end
endmodule
`default_nettype wire
